// File: rtl/core/mmps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmps_pkg
// Shared types and fixed field widths for the min-max partition search.
// ----------------------------------------------------------------------------
package mmps_pkg;

  localparam int ELEM_W = 31;
  localparam int CFG_W  = 11;
  localparam int MMS_W  = 41;

  typedef struct packed {
    logic [ELEM_W-1:0] elem_value;
    logic              is_last;
  } in_word_t;

  typedef struct packed {
    logic [MMS_W-1:0] min_max_sum;
    logic             overflowed;
  } out_word_t;

  // Status returned by the scan engine at the end of one greedy pass
  typedef struct packed {
    logic done;
    logic fits;
  } scan_res_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_START,
    ST_MID,
    ST_SCAN,
    ST_POST
  } mmps_state_t;

endpackage

// File: rtl/core/mmps_store_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmps_store_scan
// Value store and greedy pass engine: counts the contiguous parts needed
// for a trial limit, streaming the store through its one read port.
// ----------------------------------------------------------------------------
module mmps_store_scan
  import mmps_pkg::*;
#(
  parameter int MAX_ITEMS  = 1024,
  parameter int VALUE_BITS = 31
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   wr_en,
  input  logic [(MAX_ITEMS > 1 ? $clog2(MAX_ITEMS) : 1)-1:0] wr_addr,
  input  logic [VALUE_BITS-1:0]                  wr_data,
  input  logic                                   start,
  input  logic [$clog2(MAX_ITEMS+1)-1:0]         count,
  input  logic [VALUE_BITS+$clog2(MAX_ITEMS+1)-1:0] lim,
  input  logic [CFG_W-1:0]                       parts_allowed,
  output scan_res_t                              res
);

  localparam int ADDR_W  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W   = $clog2(MAX_ITEMS + 1);
  localparam int SUM_W   = VALUE_BITS + CNT_W;
  localparam int PART_W  = CNT_W + 1;
  localparam int PCMP_W  = (PART_W > CFG_W) ? PART_W : CFG_W;

  logic [VALUE_BITS-1:0] mem [MAX_ITEMS];

  logic                  busy;
  logic [CNT_W-1:0]      issue_idx;
  logic                  rd_en;
  logic                  rd_valid;
  logic [VALUE_BITS-1:0] rd_data;
  logic [SUM_W-1:0]      acc;
  logic [PART_W-1:0]     parts;
  logic                  too_big;
  logic [SUM_W:0]        acc_sum;
  logic [SUM_W-1:0]      rd_ext;

  // Writes happen only while loading and reads only while scanning,
  // so the two never meet on one entry.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[issue_idx[ADDR_W-1:0]];
    end
  end

  assign rd_en   = busy && (issue_idx < count);
  assign rd_ext  = SUM_W'(rd_data);
  assign acc_sum = {1'b0, acc} + {1'b0, rd_ext};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= rd_en;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && !rd_en && !rd_valid) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      issue_idx <= '0;
      acc       <= '0;
      parts     <= PART_W'(1);
      too_big   <= 1'b0;
    end else begin
      if (rd_en) begin
        issue_idx <= issue_idx + CNT_W'(1);
      end
      if (rd_valid) begin
        if (rd_ext > lim) begin
          too_big <= 1'b1;
        end
        // open a new part when this value would push the current one over
        if (acc_sum > {1'b0, lim}) begin
          parts <= parts + PART_W'(1);
          acc   <= rd_ext;
        end else begin
          acc   <= acc_sum[SUM_W-1:0];
        end
      end
    end
  end

  assign res.done = busy && !rd_en && !rd_valid;
  assign res.fits = !too_big && (PCMP_W'(parts) <= PCMP_W'(parts_allowed));

endmodule

// File: rtl/core/min_max_partition_search_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_max_partition_search_top
// Stores a data set and finds the smallest limit on the largest part sum.
// ----------------------------------------------------------------------------
// Values load one word per cycle, while in_stall is low, into the value store;
// the word marked last ends the set. The search then holds the input stalled
// over P trial limits, at most ceil(log2(total - max + 1)) + 1: each trial
// is one pass over the store through its single read port, one entry a cycle.
// Words past MAX_ITEMS are dropped and flagged in the result. The result sits
// in an output register, so the next set may start loading while it waits.
module min_max_partition_search_top
  import mmps_pkg::*;
#(
  parameter int MAX_ITEMS  = 1024,
  parameter int VALUE_BITS = 31
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_word_t         in_word,
  output logic             out_valid,
  input  logic             out_stall,
  output out_word_t        out_word
);

  localparam int ADDR_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int SUM_W  = VALUE_BITS + CNT_W;

  mmps_state_t state, state_next;

  logic [CFG_W-1:0]      part_limit;
  logic [CFG_W-1:0]      parts_allowed;
  logic [CNT_W-1:0]      item_count;
  logic [VALUE_BITS-1:0] running_max;
  logic [SUM_W-1:0]      running_total;
  logic                  overflow_flag;
  logic [SUM_W-1:0]      search_low;
  logic [SUM_W-1:0]      search_high;
  logic [SUM_W-1:0]      best_limit;
  logic [SUM_W-1:0]      mid;
  logic [SUM_W:0]        mid_sum;

  logic                  in_take;
  logic                  has_room;
  logic [VALUE_BITS-1:0] value;
  logic                  scan_start;
  logic                  post_free;
  logic                  search_end;
  scan_res_t             scan_res;

  assign value    = VALUE_BITS'(in_word.elem_value);
  assign has_room = item_count < CNT_W'(MAX_ITEMS);
  assign in_take  = in_valid && !in_stall;
  assign post_free = !out_valid || !out_stall;
  assign parts_allowed = (part_limit == '0) ? CFG_W'(1) : part_limit;
  assign mid_sum  = {1'b0, search_low} + {1'b0, search_high};

  // Search ends on the trial that closes the interval
  always_comb begin
    if (scan_res.fits) begin
      search_end = (mid == search_low);
    end else begin
      search_end = (mid == search_high);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      part_limit <= CFG_W'(1);
    end else if (cfg_wr_en) begin
      part_limit <= cfg_wr_data;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (in_take && in_word.is_last) begin
          state_next = ST_START;
        end
      end
      ST_START: state_next = ST_MID;
      ST_MID:   state_next = ST_SCAN;
      ST_SCAN: begin
        if (scan_res.done) begin
          state_next = search_end ? ST_POST : ST_MID;
        end
      end
      ST_POST: begin
        if (post_free) begin
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // outputs
  always_comb begin
    in_stall   = 1'b1;
    scan_start = 1'b0;
    unique case (state)
      ST_LOAD:  in_stall = 1'b0;
      ST_MID:   scan_start = 1'b1;
      ST_START, ST_SCAN, ST_POST: begin
        in_stall = 1'b1;
      end
      default:  in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // set accumulation
  always_ff @(posedge clk) begin
    if (rst) begin
      item_count    <= '0;
      running_max   <= '0;
      running_total <= '0;
      overflow_flag <= 1'b0;
    end else if (state == ST_POST && post_free) begin
      item_count    <= '0;
      running_max   <= '0;
      running_total <= '0;
      overflow_flag <= 1'b0;
    end else if (in_take) begin
      if (has_room) begin
        item_count    <= item_count + CNT_W'(1);
        running_total <= running_total + SUM_W'(value);
        if (value > running_max) begin
          running_max <= value;
        end
      end else begin
        overflow_flag <= 1'b1;
      end
    end
  end

  // binary search over the limit
  always_ff @(posedge clk) begin
    unique case (state)
      ST_START: begin
        search_low  <= SUM_W'(running_max);
        search_high <= running_total;
        best_limit  <= running_total;
      end
      ST_MID: begin
        mid <= mid_sum[SUM_W:1];
      end
      ST_SCAN: begin
        if (scan_res.done) begin
          if (scan_res.fits) begin
            best_limit  <= mid;
            search_high <= mid - SUM_W'(1);
          end else begin
            search_low  <= mid + SUM_W'(1);
          end
        end
      end
      ST_LOAD, ST_POST: begin
        best_limit <= best_limit;
      end
      default: begin
        best_limit <= best_limit;
      end
    endcase
  end

  // result register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_POST && post_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_POST && post_free) begin
      out_word.min_max_sum <= MMS_W'(best_limit);
      out_word.overflowed  <= overflow_flag;
    end
  end

  mmps_store_scan #(
    .MAX_ITEMS  (MAX_ITEMS),
    .VALUE_BITS (VALUE_BITS)
  ) u_store_scan (
    .clk           (clk),
    .rst           (rst),
    .wr_en         (in_take && has_room),
    .wr_addr       (item_count[ADDR_W-1:0]),
    .wr_data       (value),
    .start         (scan_start),
    .count         (item_count),
    .lim           (mid),
    .parts_allowed (parts_allowed),
    .res           (scan_res)
  );

  a_bounds_ordered: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MID) |-> (search_low <= search_high))
    else $error("search bounds crossed before a trial");

  a_mid_in_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (mid >= search_low && mid <= search_high))
    else $error("trial limit outside search bounds");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    item_count <= CNT_W'(MAX_ITEMS))
    else $error("item count beyond store capacity");

  a_post_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == ST_POST && post_free) |=> (out_valid && state == ST_LOAD))
    else $error("result not posted when output was free");

endmodule

// File: verif/min_max_partition_search_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_max_partition_search_top_tb
// Streams data sets into the partition search and checks every result word
// against a behavioural predictor of the smallest largest-part sum, across
// several part limits, a full store and an overflowing one, with random
// gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module min_max_partition_search_top_tb;
  import mmps_pkg::*;

  localparam int MAX_ITEMS    = 1024;
  localparam int RANDOM_WORDS = 950;
  localparam int PHASES       = 7;
  localparam int SETTLE       = 16;
  // longest search is about 42 passes over a full store
  localparam int QUIET_LIMIT  = 200000;
  localparam logic [ELEM_W-1:0] ELEM_MAX = '1;

  typedef enum int {
    VALS_SMALL,
    VALS_MID,
    VALS_FULL,
    VALS_EDGE
  } spread_t;

  logic             clk         = 1'b0;
  logic             rst         = 1'b1;
  logic             cfg_wr_en   = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;
  logic             in_valid    = 1'b0;
  logic             in_stall;
  in_word_t         in_word     = '0;
  logic             out_valid;
  logic             out_stall   = 1'b0;
  out_word_t        out_word;

  min_max_partition_search_top #(
    .MAX_ITEMS (MAX_ITEMS),
    .VALUE_BITS(ELEM_W)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word)
  );

  always #1 clk = ~clk;

  in_word_t          pending_words[$];
  logic [ELEM_W-1:0] staged[$];
  int                words_queued   = 0;
  int                words_accepted = 0;
  int                words_driven   = 0;
  int                results_taken  = 0;
  int                mismatches     = 0;
  int                quiet_cycles   = 0;

  // predictor state: the current set as stored, the drop flag and the limit
  logic [ELEM_W-1:0] set_values[$];
  logic              drop_seen   = 1'b0;
  logic [CFG_W-1:0]  limit_copy  = 11'd1;
  out_word_t         expected_results[$];
  out_word_t         oldest;

  // greedy pass: can the set be cut into at most parts_allowed runs <= lim?
  function automatic bit fits_within(input logic [MMS_W:0] lim, input int parts_allowed);
    int              parts;
    logic [MMS_W:0]  acc;
    logic [MMS_W:0]  v;
    parts = 1;
    acc   = '0;
    foreach (set_values[i]) begin
      v = {11'd0, set_values[i]};
      if (v > lim) return 1'b0;
      if (acc + v > lim) begin
        parts++;
        acc = v;
      end else begin
        acc += v;
      end
    end
    return parts <= parts_allowed;
  endfunction

  function automatic logic [MMS_W-1:0] smallest_peak(input int parts_allowed);
    logic [MMS_W:0] lo, hi, mid, best;
    lo = '0;
    hi = '0;
    foreach (set_values[i]) begin
      if ({11'd0, set_values[i]} > lo) lo = {11'd0, set_values[i]};
      hi += {11'd0, set_values[i]};
    end
    best = hi;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (fits_within(mid, parts_allowed)) begin
        best = mid;
        if (mid == lo) break;
        hi = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
    return best[MMS_W-1:0];
  endfunction

  task automatic note_mismatch(input string what, input logic [MMS_W-1:0] want,
                               input logic [MMS_W-1:0] got);
    if (mismatches < 10)
      $display("mismatch %0d: %s expected %0d got %0d", mismatches + 1, what, want, got);
    mismatches++;
  endtask

  // input driver: hold a word until taken, then maybe idle
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_words.size() != 0 &&
          ((words_driven >= 300 && words_driven < 560) || $urandom_range(0, 99) >= 9)) begin
        in_valid <= 1'b1;
        in_word  <= pending_words.pop_front();
        words_driven++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output stall, with a stretch of results taken without any stall
  always @(posedge clk) begin
    if (out_valid && !out_stall) results_taken++;
    if (rst)
      out_stall <= 1'b0;
    else if (results_taken >= 20 && results_taken < 45)
      out_stall <= 1'b0;
    else
      out_stall <= ($urandom_range(0, 99) < 9);
  end

  // monitor: predict on each accepted input word, check each result word
  always @(posedge clk) begin
    if (!rst) begin
      quiet_cycles++;
      if (cfg_wr_en) begin
        limit_copy   = cfg_wr_data;
        quiet_cycles = 0;
      end
      if (in_valid && !in_stall) begin
        quiet_cycles = 0;
        words_accepted++;
        if (set_values.size() < MAX_ITEMS)
          set_values.push_back(in_word.elem_value);
        else
          drop_seen = 1'b1;
        if (in_word.is_last) begin
          // a zero limit behaves as one
          expected_results.push_back('{
            min_max_sum: smallest_peak(limit_copy == 0 ? 1 : int'(limit_copy)),
            overflowed:  drop_seen
          });
          set_values.delete();
          drop_seen = 1'b0;
        end
      end
      if (out_valid && !out_stall) begin
        quiet_cycles = 0;
        if (expected_results.size() == 0) begin
          note_mismatch("result with none pending, min_max_sum", '0, out_word.min_max_sum);
        end else begin
          oldest = expected_results.pop_front();
          if (out_word.min_max_sum !== oldest.min_max_sum)
            note_mismatch("min_max_sum", oldest.min_max_sum, out_word.min_max_sum);
          if (out_word.overflowed !== oldest.overflowed)
            note_mismatch("overflowed", MMS_W'(oldest.overflowed),
                          MMS_W'(out_word.overflowed));
        end
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic stage(input logic [ELEM_W-1:0] v);
    staged.push_back(v);
  endtask

  // queue the staged values as one set, last word marked
  task automatic queue_set();
    foreach (staged[i])
      pending_words.push_back('{elem_value: staged[i], is_last: i == staged.size() - 1});
    words_queued += staged.size();
    staged.delete();
  endtask

  function automatic logic [ELEM_W-1:0] pick_value(input spread_t spread);
    logic [ELEM_W-1:0] v;
    case (spread)
      VALS_SMALL: v = ELEM_W'($urandom_range(0, 15));
      VALS_MID:   v = ELEM_W'($urandom_range(0, 1000));
      VALS_FULL:  v = ELEM_W'($urandom);
      default: begin
        case ($urandom_range(0, 4))
          0:       v = '0;
          1:       v = ELEM_MAX;
          2:       v = ELEM_MAX - ELEM_W'(1);
          3:       v = ELEM_W'(1);
          default: v = ELEM_W'($urandom);
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic random_set(input int n, input spread_t spread);
    for (int i = 0; i < n; i++) stage(pick_value(spread));
    queue_set();
  endtask

  function automatic int set_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 12);
    if (r < 95) return $urandom_range(13, 40);
    return $urandom_range(41, 100);
  endfunction

  // block idle: every word taken and every result back
  task automatic wait_drained();
    do @(negedge clk);
    while (words_accepted != words_queued || expected_results.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_limit(input logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    logic [CFG_W-1:0] plan[PHASES];
    int               budget;
    int               n;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // part limit at its reset value of one
    stage('0); queue_set();
    stage(ELEM_MAX); queue_set();
    stage(ELEM_W'(5)); stage(ELEM_W'(1)); stage(ELEM_W'(9)); stage(ELEM_W'(3)); queue_set();
    wait_drained();

    // zero limit acts as one
    write_limit('0);
    stage(ELEM_W'(4)); stage(ELEM_W'(4)); stage(ELEM_W'(4)); stage(ELEM_W'(4)); queue_set();
    wait_drained();

    write_limit(11'd3);
    stage(ELEM_W'(7)); stage(ELEM_W'(2)); stage(ELEM_W'(5)); stage(ELEM_W'(10));
    stage(ELEM_W'(8)); queue_set();
    stage('0); stage('0); stage('0); queue_set();
    stage(ELEM_MAX); stage(ELEM_MAX); stage(ELEM_MAX); stage(ELEM_MAX); queue_set();
    wait_drained();

    // more parts allowed than items
    write_limit('1);
    stage(ELEM_W'(1)); stage(ELEM_W'(2)); stage(ELEM_W'(3)); queue_set();

    plan = '{11'd1024, 11'd1, 11'd2, 11'd0, 11'($urandom_range(1, 8)),
             11'($urandom_range(0, 2047)), 11'($urandom_range(2, 64))};
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      write_limit(plan[p]);
      budget = RANDOM_WORDS / PHASES;
      while (budget > 0) begin
        n = set_size();
        random_set(n, spread_t'($urandom_range(0, 3)));
        budget -= n;
      end
    end

    // a store filled exactly, then one that overflows, then a short clean set
    wait_drained();
    write_limit(11'($urandom_range(2, 40)));
    random_set(MAX_ITEMS, VALS_FULL);
    random_set(MAX_ITEMS + $urandom_range(1, 6), VALS_MID);
    random_set(3, VALS_SMALL);
    wait_drained();

    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/mmps_pkg.sv
rtl/core/mmps_store_scan.sv
rtl/core/min_max_partition_search_top.sv
verif/min_max_partition_search_top_tb.sv
